>>> hdl/sdspi_pkg.sv
`default_nettype none
package sdspi_pkg;

	localparam int STORE_BYTES_DEF = 65536;
	localparam int CAP_W = 40;

	localparam logic [3:0] MODE_IDLE     = 4'd0;
	localparam logic [3:0] MODE_READY    = 4'd1;
	localparam logic [3:0] MODE_TRANSFER = 4'd4;
	localparam logic [3:0] MODE_SENDING  = 4'd5;
	localparam logic [3:0] MODE_RECEIVE  = 4'd6;

	localparam logic [7:0] ERR_ILLEGAL = 8'h04;

	localparam logic [5:0] OP_GO_IDLE   = 6'd0;
	localparam logic [5:0] OP_SEND_OP   = 6'd1;
	localparam logic [5:0] OP_IF_COND   = 6'd8;
	localparam logic [5:0] OP_SEND_CSD  = 6'd9;
	localparam logic [5:0] OP_STOP      = 6'd12;
	localparam logic [5:0] OP_STATUS    = 6'd13;
	localparam logic [5:0] OP_BLOCKLEN  = 6'd16;
	localparam logic [5:0] OP_READ_one  = 6'd17;
	localparam logic [5:0] OP_READ_MULT = 6'd18;
	localparam logic [5:0] OP_WRITE     = 6'd24;
	localparam logic [5:0] OP_APP_OP    = 6'd41;
	localparam logic [5:0] OP_APP_CMD   = 6'd55;
	localparam logic [5:0] OP_READ_OCR  = 6'd58;

	localparam logic [0:0] CFG_HIGH_CAP = 1'd0;
	localparam logic [0:0] CFG_CAPACITY = 1'd1;

	localparam logic [7:0] TOK_START    = 8'hFE;
	localparam logic [7:0] TOK_RD_ERR   = 8'h03;
	localparam logic [7:0] TOK_WR_OK    = 8'h05;
	localparam logic [7:0] TOK_WR_ERR   = 8'h0D;
	localparam logic [7:0] BYTE_CHECK   = 8'hAA;

	typedef struct packed {
		logic capture;
		logic wr_step;
		logic csd_step;
		logic rd_reload;
		logic rd_select;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic csd_start;
		logic csd_done;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> hdl/sdspi_ram.sv
`default_nettype none
module sdspi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> hdl/sdspi_ctrl.sv
`default_nettype none
module sdspi_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 func,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output sdspi_pkg::ctrl_cmd_t      cmd,
	input  wire sdspi_pkg::dp_stat_t  stat
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_WR   = 6'b000010,
		S_CSD  = 6'b000100,
		S_RD1  = 6'b001000,
		S_RD2  = 6'b010000,
		S_RD3  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = func ? S_WR : S_RD1;
				end
			end
			S_WR: begin
				cmd.wr_step = 1'b1;
				state_d = stat.csd_start ? S_CSD : S_IDLE;
			end
			S_CSD: begin
				cmd.csd_step = 1'b1;
				if (stat.csd_done) begin
					state_d = S_IDLE;
				end
			end
			S_RD1: begin
				cmd.rd_reload = 1'b1;
				state_d = S_RD2;
			end
			S_RD2: begin
				cmd.rd_select = 1'b1;
				state_d = S_RD3;
			end
			S_RD3: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

>>> hdl/sdspi_dp.sv
`default_nettype none
module sdspi_dp #(
	parameter int STORE_BYTES = sdspi_pkg::STORE_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [0:0]                   cfg_index,
	input  wire logic [sdspi_pkg::CAP_W-1:0]  cfg_data,
	input  wire logic [7:0]                   wdata,
	output logic      [7:0]                   rdata,
	input  wire sdspi_pkg::ctrl_cmd_t         cmd,
	output sdspi_pkg::dp_stat_t               stat
);
	localparam int AW = $clog2(STORE_BYTES);
	localparam logic [32:0] STORE_LIM = 33'(STORE_BYTES);

	logic                        hc_q;
	logic [sdspi_pkg::CAP_W-1:0] cap_q;
	logic [3:0]                  mode_q;
	logic [7:0]                  err_q;
	logic [2:0]                  fc_q;
	logic [5:0]                  lop_q;
	logic [10:0]                 len_q, idx_q, bs_q, inc_q;
	logic [31:0]                 pos_q;
	logic                        app_q, tok_q, blk_q;
	logic [1:0]                  hdr_q;

	logic [7:0]  wdata_q;
	logic [7:0]  frame_q [5];
	logic [7:0]  rep_q [20];
	logic [7:0]  rdata_q, byte_q;
	logic        use_ram_q;
	logic [30:0] blocks_q;
	logic [3:0]  lg_q;

	logic        recv, data_wr, fr_wr, fr_take, fr_bad_end, cmd_fire, cmd_ill;
	logic [5:0]  opc;
	logic [31:0] arg, pos_cmd, pos_rl;
	logic        bs10, fits_q, fits_cmd, fits_rl;
	logic [10:0] ic_next;
	logic        dfin, dstore;
	logic        has, in_blk;
	logic [10:0] hdr_ext;
	logic [7:0]  rep_rd, sel_byte;
	logic [30:0] q, cs;
	logic        cont;
	logic [11:0] cs_f;
	logic [2:0]  lgm;
	logic [20:0] q_hc;
	logic [21:0] cs_hc;
	logic [7:0]  ram_rdata;
	logic        ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;

	function automatic logic fits(input logic [31:0] p, input logic [10:0] bs);
		return ({1'b0, p} + {22'b0, bs}) <= STORE_LIM;
	endfunction

	assign recv       = (mode_q == sdspi_pkg::MODE_RECEIVE);
	assign data_wr    = cmd.wr_step && recv;
	assign fr_wr      = cmd.wr_step && !recv;
	assign fr_bad_end = fr_wr && (fc_q == 3'd5) && !wdata_q[0];
	assign fr_take    = fr_wr && !((fc_q == 3'd0) && (wdata_q[7:6] != 2'b01)) && !fr_bad_end;
	assign cmd_fire   = fr_take && (fc_q == 3'd5);
	assign opc        = frame_q[0][5:0];
	assign arg        = {frame_q[1], frame_q[2], frame_q[3], frame_q[4]};
	assign bs10       = (bs_q == 11'd1024);
	assign pos_cmd    = hc_q ? (bs10 ? (arg << 10) : (arg << 9)) : arg;
	assign pos_rl     = pos_q + {21'b0, bs_q};
	assign fits_q     = fits(pos_q, bs_q);
	assign fits_cmd   = fits(pos_cmd, bs_q);
	assign fits_rl    = fits(pos_rl, bs_q);

	always_comb begin
		unique case (opc) inside
			sdspi_pkg::OP_BLOCKLEN: cmd_ill = !(!hc_q && (arg == 32'd512 || arg == 32'd1024));
			sdspi_pkg::OP_APP_OP:   cmd_ill = !app_q;
			sdspi_pkg::OP_GO_IDLE, sdspi_pkg::OP_SEND_OP, sdspi_pkg::OP_IF_COND,
			sdspi_pkg::OP_SEND_CSD, sdspi_pkg::OP_STOP, sdspi_pkg::OP_STATUS,
			sdspi_pkg::OP_READ_one, sdspi_pkg::OP_READ_MULT, sdspi_pkg::OP_WRITE,
			sdspi_pkg::OP_APP_CMD, sdspi_pkg::OP_READ_OCR: cmd_ill = 1'b0;
			default: cmd_ill = 1'b1;
		endcase
	end

	assign ic_next = inc_q + 11'd1;
	assign dfin    = data_wr && (ic_next >= bs_q + 11'd3);
	assign dstore  = data_wr && (inc_q != 11'd0) && (inc_q <= bs_q) && tok_q && fits_q;

	assign hdr_ext = {9'b0, hdr_q};
	assign has     = idx_q < len_q;
	assign in_blk  = blk_q && (idx_q >= hdr_ext) && (idx_q < hdr_ext + bs_q);
	assign rep_rd  = (idx_q < 11'd20) ? rep_q[idx_q[4:0]] : 8'h00;

	always_comb begin
		if (!has) begin
			sel_byte = err_q | {7'b0, mode_q == sdspi_pkg::MODE_IDLE};
		end else if (blk_q) begin
			sel_byte = (idx_q < hdr_ext) ? rep_rd : 8'h00;
		end else begin
			sel_byte = rep_rd;
		end
	end

	// CSD size and multiplier search, one step per cycle
	assign q    = blocks_q >> lg_q;
	assign cs   = q - 31'd1;
	assign cont = (q != 31'd0) && (cs > 31'd4095) && (lg_q < 4'd9);
	assign cs_f = (q == 31'd0) ? 12'd0 : ((cs > 31'd4095) ? 12'd4095 : cs[11:0]);
	assign lgm  = 3'(lg_q - 4'd2);
	assign q_hc  = cap_q[39:19];
	assign cs_hc = (q_hc == 21'd0) ? 22'd0 : {1'b0, q_hc - 21'd1};

	assign stat.csd_start = cmd_fire && !cmd_ill && (opc == sdspi_pkg::OP_SEND_CSD) && !hc_q;
	assign stat.csd_done  = !cont;

	assign ram_re    = cmd.rd_select && has && in_blk;
	assign ram_raddr = AW'(pos_q + {21'b0, idx_q - hdr_ext});
	assign ram_waddr = AW'(pos_q + {21'b0, inc_q - 11'd1});

	sdspi_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
		.clk   (clk),
		.we    (dstore),
		.waddr (ram_waddr),
		.wdata (wdata_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rdata = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q   <= 1'b0;
			cap_q  <= 40'd1073741824;
			mode_q <= sdspi_pkg::MODE_IDLE;
			err_q  <= 8'h00;
			fc_q   <= 3'd0;
			lop_q  <= 6'd0;
			len_q  <= 11'd0;
			idx_q  <= 11'd0;
			bs_q   <= 11'd512;
			pos_q  <= 32'd0;
			app_q  <= 1'b0;
			inc_q  <= 11'd0;
			tok_q  <= 1'b0;
			blk_q  <= 1'b0;
			hdr_q  <= 2'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sdspi_pkg::CFG_HIGH_CAP: hc_q <= cfg_data[0];
					sdspi_pkg::CFG_CAPACITY: cap_q <= cfg_data;
					default: ;
				endcase
			end
			if (fr_bad_end) begin
				fc_q <= 3'd0;
			end else if (fr_take) begin
				fc_q <= (fc_q == 3'd5) ? 3'd0 : fc_q + 3'd1;
			end
			if (cmd_fire) begin
				lop_q <= opc;
				err_q <= 8'h00;
				len_q <= 11'd0;
				idx_q <= 11'd0;
				blk_q <= 1'b0;
				if (cmd_ill) begin
					mode_q <= sdspi_pkg::MODE_IDLE;
					err_q  <= sdspi_pkg::ERR_ILLEGAL;
					app_q  <= 1'b0;
				end else begin
					unique case (opc) inside
						sdspi_pkg::OP_GO_IDLE: mode_q <= sdspi_pkg::MODE_IDLE;
						sdspi_pkg::OP_SEND_OP: len_q <= 11'd1;
						sdspi_pkg::OP_IF_COND: err_q <= sdspi_pkg::ERR_ILLEGAL;
						sdspi_pkg::OP_SEND_CSD: len_q <= 11'd20;
						sdspi_pkg::OP_STOP: begin
							mode_q <= sdspi_pkg::MODE_TRANSFER;
							len_q  <= 11'd2;
						end
						sdspi_pkg::OP_STATUS: len_q <= 11'd2;
						sdspi_pkg::OP_BLOCKLEN: bs_q <= arg[10:0];
						sdspi_pkg::OP_READ_one, sdspi_pkg::OP_READ_MULT: begin
							pos_q  <= pos_cmd;
							mode_q <= sdspi_pkg::MODE_SENDING;
							blk_q  <= fits_cmd;
							hdr_q  <= 2'd2;
							len_q  <= fits_cmd ? 11'd4 + bs_q : 11'd2;
						end
						sdspi_pkg::OP_WRITE: begin
							pos_q  <= pos_cmd;
							mode_q <= sdspi_pkg::MODE_RECEIVE;
							inc_q  <= 11'd0;
							len_q  <= 11'd1;
						end
						sdspi_pkg::OP_APP_OP: begin
							app_q  <= 1'b0;
							mode_q <= sdspi_pkg::MODE_READY;
							len_q  <= 11'd1;
						end
						sdspi_pkg::OP_APP_CMD: app_q <= 1'b1;
						sdspi_pkg::OP_READ_OCR: begin
							mode_q <= sdspi_pkg::MODE_SENDING;
							len_q  <= 11'd5;
						end
						default: ;
					endcase
				end
			end
			if (data_wr) begin
				if (inc_q == 11'd0) begin
					tok_q <= (wdata_q == sdspi_pkg::TOK_START);
				end
				inc_q <= ic_next;
				if (dfin) begin
					blk_q  <= 1'b0;
					idx_q  <= 11'd0;
					len_q  <= (tok_q && fits_q) ? 11'd2 : 11'd1;
					inc_q  <= 11'd0;
					mode_q <= sdspi_pkg::MODE_TRANSFER;
				end
			end
			if (cmd.rd_reload && !has && (lop_q == sdspi_pkg::OP_READ_MULT)) begin
				pos_q <= pos_rl;
				blk_q <= fits_rl;
				hdr_q <= 2'd1;
				len_q <= fits_rl ? 11'd3 + bs_q : 11'd1;
				idx_q <= 11'd0;
			end
			if (cmd.rd_select) begin
				if (has) begin
					idx_q <= idx_q + 11'd1;
				end else begin
					err_q <= 8'h00;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			wdata_q <= wdata;
		end
		if (fr_take && fc_q < 3'd5) begin
			frame_q[fc_q] <= wdata_q;
		end
		if (cmd_fire && !cmd_ill) begin
			unique case (opc) inside
				sdspi_pkg::OP_SEND_OP, sdspi_pkg::OP_WRITE, sdspi_pkg::OP_APP_OP: begin
					rep_q[0] <= 8'h00;
				end
				sdspi_pkg::OP_SEND_CSD: begin
					rep_q[0] <= 8'h00;
					rep_q[1] <= sdspi_pkg::TOK_START;
					for (int i = 2; i < 20; i++) begin
						rep_q[i] <= 8'h00;
					end
					if (hc_q) begin
						rep_q[9]  <= {2'b0, cs_hc[21:16]};
						rep_q[10] <= cs_hc[15:8];
						rep_q[11] <= cs_hc[7:0];
					end
				end
				sdspi_pkg::OP_STOP: begin
					rep_q[0] <= 8'h01;
					rep_q[1] <= sdspi_pkg::BYTE_CHECK;
				end
				sdspi_pkg::OP_STATUS: begin
					rep_q[0] <= {7'b0, mode_q == sdspi_pkg::MODE_IDLE};
					rep_q[1] <= 8'h00;
				end
				sdspi_pkg::OP_READ_one, sdspi_pkg::OP_READ_MULT: begin
					rep_q[0] <= 8'h00;
					rep_q[1] <= fits_cmd ? sdspi_pkg::TOK_START : sdspi_pkg::TOK_RD_ERR;
				end
				sdspi_pkg::OP_READ_OCR: begin
					rep_q[0] <= 8'h00;
					rep_q[1] <= {1'b1, hc_q, 6'b0};
					rep_q[2] <= 8'h00;
					rep_q[3] <= 8'h00;
					rep_q[4] <= 8'h00;
				end
				default: ;
			endcase
		end
		if (stat.csd_start) begin
			blocks_q <= bs10 ? {1'b0, cap_q[39:10]} : cap_q[39:9];
			lg_q     <= 4'd2;
		end
		if (cmd.csd_step) begin
			if (cont) begin
				lg_q <= lg_q + 4'd1;
			end else begin
				rep_q[7]  <= bs10 ? 8'd10 : 8'd9;
				rep_q[8]  <= {6'b0, cs_f[11:10]};
				rep_q[9]  <= cs_f[9:2];
				rep_q[10] <= {cs_f[1:0], 6'b0};
				rep_q[11] <= {6'b0, lgm[2:1]};
				rep_q[12] <= {lgm[0], 7'b0};
			end
		end
		if (dfin) begin
			rep_q[0] <= (tok_q && fits_q) ? sdspi_pkg::TOK_WR_OK : sdspi_pkg::TOK_WR_ERR;
			rep_q[1] <= sdspi_pkg::BYTE_CHECK;
		end
		if (cmd.rd_reload && !has && (lop_q == sdspi_pkg::OP_READ_MULT)) begin
			rep_q[0] <= fits_rl ? sdspi_pkg::TOK_START : sdspi_pkg::TOK_RD_ERR;
		end
		if (cmd.rd_select) begin
			byte_q    <= sel_byte;
			use_ram_q <= has && in_blk;
		end
		if (cmd.out_load) begin
			rdata_q <= use_ram_q ? ram_rdata : byte_q;
		end
	end
endmodule
`default_nettype wire

>>> hdl/sd_card_spi_mode_target.sv
// SD card target in SPI mode, one host byte access per input transaction (func 1 = write,
// 0 = read); a read yields one output transaction with rdata. A CMD9 frame end on a
// standard-capacity card also runs the C_SIZE multiplier search (one step per cycle).
// A read runs reply bookkeeping, source select with the registered byte-store read, then
// the output register. The byte store (STORE_BYTES deep) has no reset or clearing pass;
// read only blocks that were written. The user must write configuration (index 0
// high_capacity, 1 card_capacity) only while idle; the block does not enforce it.
`default_nettype none
module sd_card_spi_mode_target #(
	parameter int STORE_BYTES = sdspi_pkg::STORE_BYTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        func,
	input  wire logic [7:0]                  wdata,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [7:0]                  rdata,
	input  wire logic                        cfg_we,
	input  wire logic [0:0]                  cfg_index,
	input  wire logic [sdspi_pkg::CAP_W-1:0] cfg_data
);
	sdspi_pkg::ctrl_cmd_t cmd;
	sdspi_pkg::dp_stat_t  stat;

	sdspi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	sdspi_dp #(.STORE_BYTES(STORE_BYTES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wdata     (wdata),
		.rdata     (rdata),
		.cmd       (cmd),
		.stat      (stat)
	);
endmodule
`default_nettype wire

>>> verif/tb.sv
`default_nettype none
module tb;

	localparam int STORE = sdspi_pkg::STORE_BYTES_DEF;
	localparam int LIMIT = 3000000;

	typedef struct packed {
		logic       wr;
		logic [7:0] byte_in;
		logic       typed;
		logic [7:0] byte_exp;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [7:0]  wdata;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  rdata;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [sdspi_pkg::CAP_W-1:0] cfg_data;

	sd_card_spi_mode_target u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .wdata(wdata),
		.out_valid(out_valid), .out_stall(out_stall), .rdata(rdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// card model state
	logic             hc;
	logic [sdspi_pkg::CAP_W-1:0] cap;
	logic [3:0]       mode;
	logic [7:0]       err_bits;
	logic [7:0]       frame [6];
	int               frame_cnt;
	logic [5:0]       opcode;
	logic [7:0]       reply [20];
	int               reply_len;
	int               reply_idx;
	int               blk_size;
	logic [31:0]      pos;
	bit               app_seen;
	int               in_cnt;
	bit               token_ok;
	bit               blk_reply;
	int               blk_hdr;
	logic [7:0]       card_mem [STORE];
	bit               mem_valid [STORE];

	logic [7:0] rdata_q [$];
	int items, reads_seen, errors, shown, cycles;
	int snd_idle, rcv_idle, hold_cnt;

	dir_row_t dir_tab [24] = '{
		'{1'b0, 8'h00, 1'b1, 8'h01},
		'{1'b1, 8'h48, 1'b0, 8'h00}, '{1'b1, 8'h00, 1'b0, 8'h00},
		'{1'b1, 8'h00, 1'b0, 8'h00}, '{1'b1, 8'h01, 1'b0, 8'h00},
		'{1'b1, 8'hAA, 1'b0, 8'h00}, '{1'b1, 8'h87, 1'b0, 8'h00},
		'{1'b0, 8'h00, 1'b1, 8'h05},
		'{1'b0, 8'hFF, 1'b1, 8'h01},
		'{1'b1, 8'h00, 1'b0, 8'h00}, '{1'b1, 8'hFF, 1'b0, 8'h00},
		'{1'b1, 8'h77, 1'b0, 8'h00}, '{1'b1, 8'h00, 1'b0, 8'h00},
		'{1'b1, 8'h00, 1'b0, 8'h00}, '{1'b1, 8'h00, 1'b0, 8'h00},
		'{1'b1, 8'h00, 1'b0, 8'h00}, '{1'b1, 8'h64, 1'b0, 8'h00},
		'{1'b1, 8'h69, 1'b0, 8'h00}, '{1'b1, 8'h00, 1'b0, 8'h00},
		'{1'b1, 8'h00, 1'b0, 8'h00}, '{1'b1, 8'h00, 1'b0, 8'h00},
		'{1'b1, 8'h00, 1'b0, 8'h00}, '{1'b1, 8'hE5, 1'b0, 8'h00},
		'{1'b0, 8'h00, 1'b1, 8'h05}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit block_fits();
		return (longint'(pos) + blk_size) <= STORE;
	endfunction

	function automatic logic [7:0] reply_byte(int i);
		longint a;
		if (!blk_reply)
			return i < 20 ? reply[i] : 8'h00;
		if (i < blk_hdr)
			return reply[i];
		if (i < blk_hdr + blk_size) begin
			a = longint'(pos) + (i - blk_hdr);
			return a < STORE ? card_mem[a] : 8'h00;
		end
		return 8'h00;
	endfunction

	function automatic void queue_block(int pre);
		if (block_fits()) begin
			reply[pre] = sdspi_pkg::TOK_START;
			blk_reply = 1;
			blk_hdr = pre + 1;
			reply_len = pre + 3 + blk_size;
		end else begin
			reply[pre] = sdspi_pkg::TOK_RD_ERR;
			blk_reply = 0;
			reply_len = pre + 1;
		end
		reply_idx = 0;
	endfunction

	function automatic void build_csd();
		longint unsigned blocks, mult, q;
		int lg;
		longint unsigned cs;
		for (int i = 2; i < 18; i++)
			reply[i] = 8'h00;
		if (!hc) begin
			blocks = cap / blk_size;
			lg = 1;
			cs = 0;
			mult = 2;
			do begin
				lg++;
				mult *= 2;
				q = blocks / mult;
				if (q == 0) begin
					cs = 0;
					break;
				end
				cs = (q - 1 > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q - 1;
			end while (cs > 4095 && lg < 9);
			if (cs > 4095)
				cs = 4095;
			reply[7]  = blk_size == 1024 ? 8'd10 : 8'd9;
			reply[8]  = 8'((cs >> 10) & 3);
			reply[9]  = 8'((cs >> 2) & 8'hFF);
			reply[10] = 8'((cs & 3) << 6);
			reply[11] = 8'(((lg - 2) >> 1) & 3);
			reply[12] = 8'(((lg - 2) & 1) << 7);
		end else begin
			q = cap / (512 * 1024);
			cs = q == 0 ? 0 : (q - 1) & 24'hFFFFFF;
			reply[9]  = 8'((cs >> 16) & 8'h3F);
			reply[10] = 8'((cs >> 8) & 8'hFF);
			reply[11] = 8'(cs & 8'hFF);
		end
	endfunction

	function automatic logic [31:0] frame_arg();
		return {frame[1], frame[2], frame[3], frame[4]};
	endfunction

	function automatic void load_position();
		pos = frame_arg();
		if (hc)
			pos = 32'(longint'(pos) * blk_size);
	endfunction

	function automatic void run_command();
		logic [31:0] v;
		err_bits = 8'h00;
		reply_len = 0;
		reply_idx = 0;
		blk_reply = 0;
		case (opcode)
			sdspi_pkg::OP_GO_IDLE: begin
				mode = sdspi_pkg::MODE_IDLE;
				return;
			end
			sdspi_pkg::OP_SEND_OP: begin
				reply[0] = 8'h00;
				reply_len = 1;
				return;
			end
			sdspi_pkg::OP_IF_COND: begin
				err_bits = sdspi_pkg::ERR_ILLEGAL;
				return;
			end
			sdspi_pkg::OP_SEND_CSD: begin
				reply[0] = 8'h00;
				reply[1] = sdspi_pkg::TOK_START;
				build_csd();
				reply[18] = 8'h00;
				reply[19] = 8'h00;
				reply_len = 20;
				return;
			end
			sdspi_pkg::OP_STOP: begin
				mode = sdspi_pkg::MODE_TRANSFER;
				reply[0] = 8'h01;
				reply[1] = sdspi_pkg::BYTE_CHECK;
				reply_len = 2;
				return;
			end
			sdspi_pkg::OP_STATUS: begin
				reply[0] = mode == sdspi_pkg::MODE_IDLE ? 8'h01 : 8'h00;
				reply[1] = 8'h00;
				reply_len = 2;
				return;
			end
			sdspi_pkg::OP_BLOCKLEN: begin
				if (!hc) begin
					v = frame_arg();
					if (v == 512 || v == 1024) begin
						blk_size = v;
						return;
					end
				end
			end
			sdspi_pkg::OP_READ_one, sdspi_pkg::OP_READ_MULT: begin
				load_position();
				mode = sdspi_pkg::MODE_SENDING;
				reply[0] = 8'h00;
				queue_block(1);
				return;
			end
			sdspi_pkg::OP_WRITE: begin
				load_position();
				mode = sdspi_pkg::MODE_RECEIVE;
				in_cnt = 0;
				reply[0] = 8'h00;
				reply_len = 1;
				return;
			end
			sdspi_pkg::OP_APP_OP: begin
				if (app_seen) begin
					app_seen = 0;
					mode = sdspi_pkg::MODE_READY;
					reply[0] = 8'h00;
					reply_len = 1;
					return;
				end
			end
			sdspi_pkg::OP_APP_CMD: begin
				app_seen = 1;
				return;
			end
			sdspi_pkg::OP_READ_OCR: begin
				mode = sdspi_pkg::MODE_SENDING;
				reply[0] = 8'h00;
				reply[1] = hc ? 8'hC0 : 8'h80;
				reply[2] = 8'h00;
				reply[3] = 8'h00;
				reply[4] = 8'h00;
				reply_len = 5;
				return;
			end
			default: ;
		endcase
		mode = sdspi_pkg::MODE_IDLE;
		err_bits = sdspi_pkg::ERR_ILLEGAL;
		app_seen = 0;
	endfunction

	function automatic void card_write(logic [7:0] v);
		longint a;
		if (mode == sdspi_pkg::MODE_RECEIVE) begin
			if (in_cnt == 0)
				token_ok = v == sdspi_pkg::TOK_START;
			else if (in_cnt <= blk_size && token_ok && block_fits()) begin
				a = longint'(pos) + in_cnt - 1;
				card_mem[a] = v;
				mem_valid[a] = 1;
			end
			in_cnt++;
			if (in_cnt >= blk_size + 3) begin
				blk_reply = 0;
				reply_idx = 0;
				if (token_ok && block_fits()) begin
					reply[0] = sdspi_pkg::TOK_WR_OK;
					reply[1] = sdspi_pkg::BYTE_CHECK;
					reply_len = 2;
				end else begin
					reply[0] = sdspi_pkg::TOK_WR_ERR;
					reply_len = 1;
				end
				in_cnt = 0;
				mode = sdspi_pkg::MODE_TRANSFER;
			end
			return;
		end
		if (frame_cnt >= 6)
			frame_cnt = 0;
		if (frame_cnt == 0 && v[7:6] != 2'b01)
			return;
		if (frame_cnt == 5 && !v[0]) begin
			frame_cnt = 0;
			return;
		end
		frame[frame_cnt] = v;
		frame_cnt++;
		if (frame_cnt == 6) begin
			opcode = frame[0][5:0];
			run_command();
			frame_cnt = 0;
		end
	endfunction

	function automatic logic [7:0] card_read();
		logic [7:0] r;
		if (reply_idx >= reply_len && opcode == sdspi_pkg::OP_READ_MULT) begin
			pos += blk_size;
			queue_block(0);
		end
		if (reply_idx < reply_len) begin
			r = reply_byte(reply_idx);
			reply_idx++;
		end else begin
			r = err_bits | (mode == sdspi_pkg::MODE_IDLE ? 8'h01 : 8'h00);
			err_bits = 8'h00;
		end
		return r;
	endfunction

	// a read must never fetch a store byte that was never written
	function automatic bit read_is_safe();
		longint a;
		if (reply_idx >= reply_len && opcode == sdspi_pkg::OP_READ_MULT)
			return 1;
		if (reply_idx < reply_len && blk_reply && reply_idx >= blk_hdr &&
				reply_idx < blk_hdr + blk_size) begin
			a = longint'(pos) + reply_idx - blk_hdr;
			return a < STORE ? mem_valid[a] : 1'b1;
		end
		return 1;
	endfunction

	task automatic drive(bit f, logic [7:0] d);
		bit ok;
		while (snd_idle > 0 && $urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		wdata <= d;
		do begin
			@(negedge clk);
			ok = !in_stall;
			@(posedge clk);
		end while (!ok);
		items++;
	endtask

	task automatic put_raw(bit f, logic [7:0] d);
		if (f)
			card_write(d);
		else
			rdata_q.push_back(card_read());
		drive(f, d);
	endtask

	task automatic send_frame(logic [5:0] op, logic [31:0] arg, bit good_end);
		logic [7:0] crc;
		crc = {7'($urandom_range(0, 127)), good_end};
		put_raw(1, {2'b01, op});
		put_raw(1, arg[31:24]);
		put_raw(1, arg[23:16]);
		put_raw(1, arg[15:8]);
		put_raw(1, arg[7:0]);
		put_raw(1, crc);
	endtask

	task automatic read_byte();
		while (!read_is_safe())
			send_frame(sdspi_pkg::OP_STOP, 32'h0, 1);
		put_raw(0, 8'($urandom));
	endtask

	task automatic read_n(int n);
		repeat (n) read_byte();
	endtask

	function automatic logic [31:0] pick_addr();
		int k;
		k = $urandom_range(0, 7);
		if ($urandom_range(0, 99) < 85)
			return hc ? 32'(k) : 32'(k * 512);
		case ($urandom_range(0, 2))
			0: return 32'hFFFF_FE00;
			1: return 32'(STORE - 100);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_sequence();
		int r;
		bit good;
		logic [5:0] op;
		logic [31:0] arg;
		r = $urandom_range(0, 99);
		good = $urandom_range(0, 99) < 95;
		if (r < 8) begin
			repeat ($urandom_range(1, 3))
				put_raw(1, 8'($urandom));
		end else if (r < 14) begin
			send_frame(sdspi_pkg::OP_APP_CMD, $urandom, 1);
			send_frame(sdspi_pkg::OP_APP_OP, $urandom, good);
			read_n($urandom_range(0, 3));
		end else if (r < 53) begin
			op = $urandom_range(0, 1) ? sdspi_pkg::OP_READ_MULT : sdspi_pkg::OP_READ_one;
			send_frame(op, pick_addr(), good);
			if (op == sdspi_pkg::OP_READ_MULT && $urandom_range(0, 99) < 4)
				read_n(40);
			else
				read_n($urandom_range(1, 30));
		end else begin
			case ($urandom_range(0, 10))
				0: op = sdspi_pkg::OP_GO_IDLE;
				1: op = sdspi_pkg::OP_SEND_OP;
				2: op = sdspi_pkg::OP_IF_COND;
				3: op = sdspi_pkg::OP_SEND_CSD;
				4: op = sdspi_pkg::OP_STOP;
				5: op = sdspi_pkg::OP_STATUS;
				6: op = sdspi_pkg::OP_BLOCKLEN;
				7: op = sdspi_pkg::OP_APP_OP;
				8: op = sdspi_pkg::OP_APP_CMD;
				9: op = sdspi_pkg::OP_READ_OCR;
				default: op = 6'($urandom);
			endcase
			arg = $urandom;
			if (op == sdspi_pkg::OP_BLOCKLEN && $urandom_range(0, 3) != 0)
				arg = $urandom_range(0, 1) ? 32'd512 : 32'd1024;
			send_frame(op, arg, good);
			read_n($urandom_range(0, 22));
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (rdata_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_card(bit hcap, logic [sdspi_pkg::CAP_W-1:0] size);
		hc = hcap;
		cap = size;
		cfg_we <= 1'b1;
		cfg_index <= sdspi_pkg::CFG_HIGH_CAP;
		cfg_data <= sdspi_pkg::CAP_W'(hcap);
		@(posedge clk);
		cfg_index <= sdspi_pkg::CFG_CAPACITY;
		cfg_data <= size;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			out_stall <= 1'b1;
			hold_cnt <= hold_cnt - 1;
		end else
			out_stall <= rcv_idle > 0 && $urandom_range(0, 99) < rcv_idle;
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			reads_seen++;
			if (rdata_q.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("unexpected read transaction: rdata %02h", rdata);
				end
			end else begin
				if (rdata !== rdata_q[0]) begin
					errors++;
					if (shown < 10) begin
						shown++;
						$display("rdata mismatch: expected %02h, actual %02h",
							rdata_q[0], rdata);
					end
				end
				void'(rdata_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("sd_card_spi_mode_target regression: fail");
			$finish;
		end
	end

	initial begin
		logic [sdspi_pkg::CAP_W-1:0] sizes [6];
		bit hcs [6];
		int stop_at;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = 1'b0;
		wdata = 8'h00;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sdspi_pkg::CFG_HIGH_CAP;
		cfg_data = '0;
		items = 0;
		reads_seen = 0;
		errors = 0;
		shown = 0;
		cycles = 0;
		hold_cnt = 0;
		snd_idle = 11;
		rcv_idle = 76;
		hc = 0;
		cap = 40'd1073741824;
		mode = sdspi_pkg::MODE_IDLE;
		err_bits = 8'h00;
		frame_cnt = 0;
		opcode = sdspi_pkg::OP_GO_IDLE;
		reply_len = 0;
		reply_idx = 0;
		blk_size = 512;
		pos = 32'h0;
		app_seen = 0;
		in_cnt = 0;
		token_ok = 0;
		blk_reply = 0;
		blk_hdr = 0;
		foreach (mem_valid[i])
			mem_valid[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].wr)
				card_write(dir_tab[i].byte_in);
			else if (dir_tab[i].typed) begin
				void'(card_read());
				rdata_q.push_back(dir_tab[i].byte_exp);
			end else
				rdata_q.push_back(card_read());
			drive(dir_tab[i].wr, dir_tab[i].byte_in);
		end
		wait_drained();

		sizes = '{40'd2097152, 40'hFF_FFFF_FFFF, 40'd1073741824,
			40'hFF_FFFF_FFFF, 40'($urandom_range(2097152, 32'hFFFF_FFFF)), 40'd2097152};
		hcs = '{0, 0, 1, 1, 0, 1};
		for (int s = 0; s < 6; s++) begin
			set_card(hcs[s], sizes[s]);
			snd_idle = s < 2 ? 11 : (s < 4 ? 76 : 0);
			rcv_idle = s < 2 ? 76 : (s < 4 ? 11 : 0);
			if (s == 0) begin
				send_frame(sdspi_pkg::OP_WRITE, 32'h0, 1);
				if (mode == sdspi_pkg::MODE_RECEIVE) begin
					put_raw(1, sdspi_pkg::TOK_START);
					repeat (blk_size + 2)
						put_raw(1, 8'($urandom));
				end
				read_n(3);
				send_frame(sdspi_pkg::OP_READ_one, 32'h0, 1);
				read_n(40);
			end
			if (s == 4) begin
				hold_cnt = 400;
				send_frame(sdspi_pkg::OP_SEND_CSD, 32'h0, 1);
				read_n(20);
			end
			stop_at = items + 30;
			while (items < stop_at)
				random_sequence();
			wait_drained();
		end

		$display("%0d byte transactions sent, %0d read bytes checked, %0d mismatches",
			items, reads_seen, errors);
		$display("six card settings (both capacity modes, smallest and largest sizes), "
			, "one block stored and read back");
		if (errors == 0 && rdata_q.size() == 0)
			$display("sd_card_spi_mode_target regression: pass");
		else
			$display("sd_card_spi_mode_target regression: fail");
		$finish;
	end

endmodule
`default_nettype wire

>>> sd_card_spi_mode_target.f
hdl/sdspi_pkg.sv
hdl/sdspi_ram.sv
hdl/sdspi_ctrl.sv
hdl/sdspi_dp.sv
hdl/sd_card_spi_mode_target.sv
verif/tb.sv
